### src/fbl_pkg.sv
// Shared types and constants for the four-bar linkage solver.
// No dependencies; the top level and fbl_taylor import this package.
`timescale 1ns / 1ps
`default_nettype none

package fbl_pkg;

	// Angle scaling and series length of the unit-circle evaluator.
	localparam int          UNIT_Q       = 30;
	localparam int          GUARD_Q      = 10;
	localparam int          TAYLOR_TERMS = 16;
	localparam logic [32:0] TWO_PI_Q30   = 33'h1921FB544;

	// Register reset values.
	localparam logic [15:0] CRANK_RST   = 16'd4096;
	localparam logic [15:0] COUPLER_RST = 16'd16384;
	localparam logic [15:0] ROCKER_RST  = 16'd8192;
	localparam logic [15:0] GROUND_RST  = 16'd16384;

	// Register index, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_CRANK   = 2'd0,
		REG_COUPLER = 2'd1,
		REG_ROCKER  = 2'd2,
		REG_GROUND  = 2'd3
	} reg_idx_t;

	// State handed from one series term to the next.
	typedef struct packed {
		logic        [31:0] t;
		logic        [30:0] phi;
		logic signed [33:0] cs;
		logic signed [33:0] sn;
	} taylor_t;

endpackage

`default_nettype wire

### src/four_bar_linkage_solver.sv
// Top level of the four-bar linkage position solver.
// Depends on fbl_pkg, fbl_delay, fbl_taylor, fbl_isqrt and fbl_div.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one crank angle per clock cycle while item_ready is high and returns the crank
// tip, the upper coupler-rocker joint and the coupler midpoint, all signed with 12 fraction
// bits, plus valid_res, which is low when the linkage cannot close (joint and midpoint
// then read zero). The latency is set mainly by the sixteen three-stage series terms, the two
// bit-per-stage square roots (28 and 26 stages) and the two bit-per-stage dividers
// (56 and 46 stages). When the result side stalls, the whole pipeline holds and
// item_ready drops. The user must write link lengths over the APB port only while no
// transfer is in flight; the block itself does not enforce this.
module four_bar_linkage_solver import fbl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [15:0]        crank_angle,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [19:0] tip_x,
	output logic signed [19:0] tip_y,
	output logic signed [19:0] joint_x,
	output logic signed [19:0] joint_y,
	output logic signed [19:0] mid_x,
	output logic signed [19:0] mid_y,
	output logic               valid_res
);

	localparam int SQ1_W  = 56;
	localparam int SQ2_W  = 52;
	localparam int DIV1_W = 56;
	localparam int DIV2_W = 46;
	localparam int LAT    = 1 + 3 * TAYLOR_TERMS + 5 + SQ1_W / 2 + 1 + DIV1_W + 3
		+ SQ2_W / 2 + 3 + DIV2_W + 2;

	logic en;
	logic [LAT-1:0] vld_q;

	// Configuration registers.
	logic [15:0] crank_q, coupler_q, rocker_q, ground_q;
	logic [31:0] csq_q, rsq_q, diffsq_q;
	logic [33:0] sumsq_q;
	reg_idx_t    widx;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crank_q   <= CRANK_RST;
			coupler_q <= COUPLER_RST;
			rocker_q  <= ROCKER_RST;
			ground_q  <= GROUND_RST;
		end else if (psel && penable && pwrite) begin
			unique case (widx)
				REG_CRANK:   crank_q   <= pwdata[15:0];
				REG_COUPLER: coupler_q <= pwdata[15:0];
				REG_ROCKER:  rocker_q  <= pwdata[15:0];
				REG_GROUND:  ground_q  <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_CRANK:   prdata = {16'b0, crank_q};
			REG_COUPLER: prdata = {16'b0, coupler_q};
			REG_ROCKER:  prdata = {16'b0, rocker_q};
			REG_GROUND:  prdata = {16'b0, ground_q};
		endcase
	end

	// Squares of the link lengths; stable in flight only if the user leaves the lengths unwritten.
	logic [16:0]        lsum;
	logic signed [16:0] ldiff;
	logic [15:0]        ldmag;

	assign lsum  = 17'(coupler_q) + 17'(rocker_q);
	assign ldiff = $signed({1'b0, coupler_q}) - $signed({1'b0, rocker_q});
	assign ldmag = ldiff[16] ? 16'(-ldiff) : ldiff[15:0];

	always_ff @(posedge clk) begin
		csq_q    <= 32'(coupler_q) * 32'(coupler_q);
		rsq_q    <= 32'(rocker_q) * 32'(rocker_q);
		sumsq_q  <= 34'(lsum) * 34'(lsum);
		diffsq_q <= 32'(ldmag) * 32'(ldmag);
	end

	// Global stall: every stage advances when the output slot is free or taken.
	assign en           = !result_valid || result_ready;
	assign item_ready   = en;
	assign result_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], item_valid};
		end
	end

	// Stage 1: angle within the quadrant in Q30.
	logic [46:0] phi_prod;
	logic [30:0] phi_s1;
	logic [1:0]  quad_s1, quad_d;

	assign phi_prod = 47'(crank_angle[13:0]) * 47'(TWO_PI_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s1  <= phi_prod[46:16];
			quad_s1 <= crank_angle[15:14];
		end
	end

	// Series chain for cosine and sine.
	taylor_t tay [TAYLOR_TERMS+1];

	assign tay[0] = '{t: 32'h4000_0000, phi: phi_s1, cs: 34'sh4000_0000, sn: '0};

	for (genvar n = 1; n <= TAYLOR_TERMS; n++) begin : g_term
		fbl_taylor #(.N(n)) u_term (
			.clk   (clk),
			.en    (en),
			.d_in  (tay[n-1]),
			.d_out (tay[n])
		);
	end

	fbl_delay #(.W(2), .D(3 * TAYLOR_TERMS)) u_quad_dly (
		.clk (clk), .en (en), .d (quad_s1), .q (quad_d)
	);

	// Stage 2: clamp the sums and map the quadrant.
	localparam logic signed [33:0] ONE_Q = 34'sh4000_0000;
	logic [30:0] csc, snc, mc_n, ms_n, mc_s2, ms_s2;
	logic        nc_n, ns_n, nc_s2, ns_s2;

	always_comb begin
		csc = (tay[TAYLOR_TERMS].cs < 0) ? 31'd0 :
			(tay[TAYLOR_TERMS].cs > ONE_Q) ? ONE_Q[30:0] : tay[TAYLOR_TERMS].cs[30:0];
		snc = (tay[TAYLOR_TERMS].sn < 0) ? 31'd0 :
			(tay[TAYLOR_TERMS].sn > ONE_Q) ? ONE_Q[30:0] : tay[TAYLOR_TERMS].sn[30:0];
		unique case (quad_d)
			2'd0: begin mc_n = csc; nc_n = 1'b0; ms_n = snc; ns_n = 1'b0; end
			2'd1: begin mc_n = snc; nc_n = 1'b1; ms_n = csc; ns_n = 1'b0; end
			2'd2: begin mc_n = csc; nc_n = 1'b1; ms_n = snc; ns_n = 1'b1; end
			2'd3: begin mc_n = snc; nc_n = 1'b0; ms_n = csc; ns_n = 1'b1; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mc_s2 <= mc_n;
			ms_s2 <= ms_n;
			nc_s2 <= nc_n;
			ns_s2 <= ns_n;
		end
	end

	// Stage 3: crank tip, rounded half away from zero.
	logic [46:0]        ptx, pty;
	logic signed [17:0] pxs, pys, tx_s3, ty_s3;

	assign ptx = 47'(crank_q) * 47'(mc_s2) + (47'd1 << (UNIT_Q - 1));
	assign pty = 47'(crank_q) * 47'(ms_s2) + (47'd1 << (UNIT_Q - 1));
	assign pxs = $signed({1'b0, ptx[46:30]});
	assign pys = $signed({1'b0, pty[46:30]});

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s3 <= nc_s2 ? -pxs : pxs;
			ty_s3 <= ns_s2 ? -pys : pys;
		end
	end

	// Stage 4: vector from the tip to the rocker pivot.
	logic signed [18:0] dx_s4, dy_s4;
	logic signed [17:0] tx_s4, ty_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s4 <= $signed({3'b0, ground_q}) - 19'(tx_s3);
			dy_s4 <= -19'(ty_s3);
			tx_s4 <= tx_s3;
			ty_s4 <= ty_s3;
		end
	end

	// Stage 5: squared components.
	logic signed [37:0] dxsq, dysq;
	logic [35:0]        dx2_s5, dy2_s5;
	logic signed [18:0] dx_s5, dy_s5;
	logic signed [17:0] tx_s5, ty_s5;

	assign dxsq = 38'(dx_s4) * 38'(dx_s4);
	assign dysq = 38'(dy_s4) * 38'(dy_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			dx2_s5 <= dxsq[35:0];
			dy2_s5 <= dysq[35:0];
			dx_s5  <= dx_s4;
			dy_s5  <= dy_s4;
			tx_s5  <= tx_s4;
			ty_s5  <= ty_s4;
		end
	end

	// Stage 6: squared distance, closure test and the law-of-cosines numerator.
	logic [35:0]        s_n, s_s6;
	logic               close_s6;
	logic signed [37:0] a2_s6;
	logic signed [18:0] dx_s6, dy_s6;
	logic signed [17:0] tx_s6, ty_s6;

	assign s_n = dx2_s5 + dy2_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s6     <= s_n;
			close_s6 <= (s_n != 36'd0) && (s_n <= 36'(sumsq_q)) && (s_n >= 36'(diffsq_q));
			a2_s6    <= $signed({6'b0, csq_q}) + $signed({2'b0, s_n}) - $signed({6'b0, rsq_q});
			dx_s6    <= dx_s5;
			dy_s6    <= dy_s5;
			tx_s6    <= tx_s5;
			ty_s6    <= ty_s5;
		end
	end

	// Distance in Q10.
	logic [SQ1_W/2-1:0] sq_d1;
	logic [112:0]       side1_d;
	logic               close_d1;
	logic signed [37:0] a2_d1;
	logic signed [17:0] tx_d1, ty_d1;
	logic signed [18:0] dx_d1, dy_d1;

	fbl_isqrt #(.W(SQ1_W)) u_sqrt_dist (
		.clk (clk), .en (en), .radicand ({s_s6, 20'b0}), .root (sq_d1)
	);

	fbl_delay #(.W(113), .D(SQ1_W / 2)) u_side1_dly (
		.clk (clk), .en (en),
		.d   ({close_s6, a2_s6, tx_s6, ty_s6, dx_s6, dy_s6}),
		.q   (side1_d)
	);

	assign {close_d1, a2_d1, tx_d1, ty_d1, dx_d1, dy_d1} = side1_d;

	// Stage 7: rounded dividend for the projection along the distance.
	logic [37:0]        a2abs;
	logic [DIV1_W-1:0]  num1_s7;
	logic               neg1_s7, close_s7;
	logic [27:0]        sq_s7;
	logic signed [17:0] tx_s7, ty_s7;
	logic signed [18:0] dx_s7, dy_s7;

	assign a2abs = a2_d1[37] ? 38'(-a2_d1) : 38'(a2_d1);

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s7  <= DIV1_W'({a2abs[35:0], 19'b0}) + DIV1_W'(sq_d1[27:1]);
			neg1_s7  <= a2_d1[37];
			close_s7 <= close_d1;
			sq_s7    <= sq_d1;
			tx_s7    <= tx_d1;
			ty_s7    <= ty_d1;
			dx_s7    <= dx_d1;
			dy_s7    <= dy_d1;
		end
	end

	logic [DIV1_W-1:0]  q1;
	logic [103:0]       side2_d;
	logic               close_d2, neg1_d2;
	logic [27:0]        sq_d2;
	logic signed [17:0] tx_d2, ty_d2;
	logic signed [18:0] dx_d2, dy_d2;

	fbl_div #(.NW(DIV1_W), .DW(28)) u_div_proj (
		.clk (clk), .en (en), .num (num1_s7), .den (sq_s7), .quo (q1)
	);

	fbl_delay #(.W(104), .D(DIV1_W)) u_side2_dly (
		.clk (clk), .en (en),
		.d   ({close_s7, neg1_s7, sq_s7, tx_s7, ty_s7, dx_s7, dy_s7}),
		.q   (side2_d)
	);

	assign {close_d2, neg1_d2, sq_d2, tx_d2, ty_d2, dx_d2, dy_d2} = side2_d;

	// Stage 8: clamp the projection to the coupler length.
	logic [25:0]        cq, mag_n, mag_s8;
	logic signed [26:0] mags, aq_s8, aq_s9, aq_s10;
	logic               close_s8, close_s9, close_s10;
	logic [27:0]        sq_s8, sq_s9, sq_s10;
	logic signed [17:0] tx_s8, ty_s8, tx_s9, ty_s9, tx_s10, ty_s10;
	logic signed [18:0] dx_s8, dy_s8, dx_s9, dy_s9, dx_s10, dy_s10;
	logic [51:0]        magsq_s9, hsq_s10;

	assign cq    = {coupler_q, 10'b0};
	assign mag_n = (q1 > DIV1_W'(cq)) ? cq : q1[25:0];
	assign mags  = $signed({1'b0, mag_n});

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s8   <= mag_n;
			aq_s8    <= neg1_d2 ? -mags : mags;
			close_s8 <= close_d2;
			sq_s8    <= sq_d2;
			tx_s8    <= tx_d2;
			ty_s8    <= ty_d2;
			dx_s8    <= dx_d2;
			dy_s8    <= dy_d2;
		end
	end

	// Stage 9: square of the projection; stage 10: height squared.
	always_ff @(posedge clk) begin
		if (en) begin
			magsq_s9  <= 52'(mag_s8) * 52'(mag_s8);
			aq_s9     <= aq_s8;
			close_s9  <= close_s8;
			sq_s9     <= sq_s8;
			tx_s9     <= tx_s8;
			ty_s9     <= ty_s8;
			dx_s9     <= dx_s8;
			dy_s9     <= dy_s8;
			hsq_s10   <= {csq_q, 20'b0} - magsq_s9;
			aq_s10    <= aq_s9;
			close_s10 <= close_s9;
			sq_s10    <= sq_s9;
			tx_s10    <= tx_s9;
			ty_s10    <= ty_s9;
			dx_s10    <= dx_s9;
			dy_s10    <= dy_s9;
		end
	end

	logic [SQ2_W/2-1:0] hq_d3;
	logic [129:0]       side3_d;
	logic               close_d3;
	logic signed [26:0] aq_d3;
	logic [27:0]        sq_d3;
	logic signed [17:0] tx_d3, ty_d3;
	logic signed [18:0] dx_d3, dy_d3;

	fbl_isqrt #(.W(SQ2_W)) u_sqrt_height (
		.clk (clk), .en (en), .radicand (hsq_s10), .root (hq_d3)
	);

	fbl_delay #(.W(130), .D(SQ2_W / 2)) u_side3_dly (
		.clk (clk), .en (en),
		.d   ({close_s10, aq_s10, sq_s10, tx_s10, ty_s10, dx_s10, dy_s10}),
		.q   (side3_d)
	);

	assign {close_d3, aq_d3, sq_d3, tx_d3, ty_d3, dx_d3, dy_d3} = side3_d;

	// Stage 11: the four rotation products.
	logic signed [26:0] hqs;
	logic signed [45:0] pax_s11, phy_s11, pay_s11, phx_s11;
	logic               close_s11, close_s12, close_s13;
	logic [27:0]        sq_s11, sq_s12, sq_s13;
	logic signed [17:0] tx_s11, ty_s11, tx_s12, ty_s12, tx_s13, ty_s13;
	logic signed [46:0] nx_s12, ny_s12;
	logic [46:0]        nxabs, nyabs;
	logic [DIV2_W-1:0]  numx_s13, numy_s13;
	logic               negx_s13, negy_s13;

	assign hqs = $signed({1'b0, hq_d3});

	always_ff @(posedge clk) begin
		if (en) begin
			pax_s11   <= 46'(aq_d3) * 46'(dx_d3);
			phy_s11   <= 46'(hqs) * 46'(dy_d3);
			pay_s11   <= 46'(aq_d3) * 46'(dy_d3);
			phx_s11   <= 46'(hqs) * 46'(dx_d3);
			close_s11 <= close_d3;
			sq_s11    <= sq_d3;
			tx_s11    <= tx_d3;
			ty_s11    <= ty_d3;
		end
	end

	// Stage 12: rotated offsets, still scaled by the distance.
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s12    <= 47'(pax_s11) - 47'(phy_s11);
			ny_s12    <= 47'(pay_s11) + 47'(phx_s11);
			close_s12 <= close_s11;
			sq_s12    <= sq_s11;
			tx_s12    <= tx_s11;
			ty_s12    <= ty_s11;
		end
	end

	// Stage 13: rounded dividends for the joint offsets.
	assign nxabs = nx_s12[46] ? 47'(-nx_s12) : 47'(nx_s12);
	assign nyabs = ny_s12[46] ? 47'(-ny_s12) : 47'(ny_s12);

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s13  <= DIV2_W'(nxabs[44:0]) + DIV2_W'(sq_s12[27:1]);
			numy_s13  <= DIV2_W'(nyabs[44:0]) + DIV2_W'(sq_s12[27:1]);
			negx_s13  <= nx_s12[46];
			negy_s13  <= ny_s12[46];
			close_s13 <= close_s12;
			sq_s13    <= sq_s12;
			tx_s13    <= tx_s12;
			ty_s13    <= ty_s12;
		end
	end

	logic [DIV2_W-1:0]  qx, qy;
	logic [38:0]        side4_d;
	logic               close_d4, negx_d4, negy_d4;
	logic signed [17:0] tx_d4, ty_d4;

	fbl_div #(.NW(DIV2_W), .DW(28)) u_div_jx (
		.clk (clk), .en (en), .num (numx_s13), .den (sq_s13), .quo (qx)
	);

	fbl_div #(.NW(DIV2_W), .DW(28)) u_div_jy (
		.clk (clk), .en (en), .num (numy_s13), .den (sq_s13), .quo (qy)
	);

	fbl_delay #(.W(39), .D(DIV2_W)) u_side4_dly (
		.clk (clk), .en (en),
		.d   ({close_s13, negx_s13, negy_s13, tx_s13, ty_s13}),
		.q   (side4_d)
	);

	assign {close_d4, negx_d4, negy_d4, tx_d4, ty_d4} = side4_d;

	// Stage 14: joint position.
	logic signed [21:0] qxs, qys, jx_s14, jy_s14;
	logic signed [17:0] tx_s14, ty_s14;
	logic               close_s14;

	assign qxs = $signed({2'b0, qx[19:0]});
	assign qys = $signed({2'b0, qy[19:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			jx_s14    <= 22'(tx_d4) + (negx_d4 ? -qxs : qxs);
			jy_s14    <= 22'(ty_d4) + (negy_d4 ? -qys : qys);
			tx_s14    <= tx_d4;
			ty_s14    <= ty_d4;
			close_s14 <= close_d4;
		end
	end

	// Stage 15: midpoint, rounded half away from zero, and the output register.
	logic signed [22:0] vx, vy, hxs, hys;
	logic [22:0]        vxabs, vyabs, hx, hy;
	logic signed [19:0] tip_x_s15, tip_y_s15, joint_x_s15, joint_y_s15, mid_x_s15, mid_y_s15;
	logic               valid_s15;

	always_comb begin
		vx    = 23'(tx_s14) + 23'(jx_s14);
		vy    = 23'(ty_s14) + 23'(jy_s14);
		vxabs = vx[22] ? 23'(-vx) : 23'(vx);
		vyabs = vy[22] ? 23'(-vy) : 23'(vy);
		hx    = (vxabs + 23'd1) >> 1;
		hy    = (vyabs + 23'd1) >> 1;
		hxs   = vx[22] ? -$signed(hx) : $signed(hx);
		hys   = vy[22] ? -$signed(hy) : $signed(hy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tip_x_s15   <= 20'(tx_s14);
			tip_y_s15   <= 20'(ty_s14);
			joint_x_s15 <= close_s14 ? jx_s14[19:0] : 20'sd0;
			joint_y_s15 <= close_s14 ? jy_s14[19:0] : 20'sd0;
			mid_x_s15   <= close_s14 ? hxs[19:0] : 20'sd0;
			mid_y_s15   <= close_s14 ? hys[19:0] : 20'sd0;
			valid_s15   <= close_s14;
		end
	end

	assign tip_x     = tip_x_s15;
	assign tip_y     = tip_y_s15;
	assign joint_x   = joint_x_s15;
	assign joint_y   = joint_y_s15;
	assign mid_x     = mid_x_s15;
	assign mid_y     = mid_y_s15;
	assign valid_res = valid_s15;

endmodule

`default_nettype wire

### src/fbl_delay.sv
// Stallable delay line for side data that rides along a pipelined unit.
// Depends on nothing but the clock and the shared stall enable.
`timescale 1ns / 1ps
`default_nettype none

module fbl_delay #(
	parameter int W = 8,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] dly_s [D];

	// Shift one place on every advancing cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= d;
			for (int i = 1; i < D; i++) begin
				dly_s[i] <= dly_s[i-1];
			end
		end
	end

	assign q = dly_s[D-1];

endmodule

`default_nettype wire

### src/fbl_taylor.sv
// One term of the cosine/sine series, three register stages deep.
// Depends on fbl_pkg for the term state struct.
`timescale 1ns / 1ps
`default_nettype none

module fbl_taylor import fbl_pkg::*; #(
	parameter int N = 1
) (
	input  logic    clk,
	input  logic    en,
	input  taylor_t d_in,
	output taylor_t d_out
);

	// Floor division by N as a reciprocal multiply with one correction step.
	localparam int          RECIP_K = 35;
	localparam logic [35:0] RECIP_M = 36'((64'd1 << RECIP_K) / N);
	localparam logic [4:0]  DIV_N   = 5'(N);
	localparam bit          ODD     = (N % 2) == 1;
	localparam bit          NEG     = ODD ? (((N - 1) / 2) % 2 == 1) : ((N / 2) % 2 == 1);

	logic        [31:0] p_s1, p_s2, e_s2, t_s3;
	logic        [30:0] phi_s1, phi_s2, phi_s3;
	logic signed [33:0] cs_s1, cs_s2, cs_s3, sn_s1, sn_s2, sn_s3;

	logic [63:0] prod1;
	logic [67:0] prod2;
	logic [36:0] eprod, rem;
	logic [31:0] q;
	logic signed [33:0] qs, cs_n, sn_n;

	// Stage 1: multiply the previous term by the angle.
	assign prod1 = 64'(d_in.t) * 64'(d_in.phi);

	// Stage 2: reciprocal estimate of the quotient.
	assign prod2 = 68'(p_s1) * 68'(RECIP_M);

	// Stage 3: fix the estimate and fold the term into its sum.
	always_comb begin
		eprod = 37'(e_s2) * 37'(DIV_N);
		rem   = 37'(p_s2) - eprod;
		q     = (rem >= 37'(DIV_N)) ? e_s2 + 32'd1 : e_s2;
		qs    = $signed({2'b00, q});
		cs_n  = cs_s2;
		sn_n  = sn_s2;
		if (ODD) begin
			sn_n = NEG ? sn_s2 - qs : sn_s2 + qs;
		end else begin
			cs_n = NEG ? cs_s2 - qs : cs_s2 + qs;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= prod1[61:30];
			phi_s1 <= d_in.phi;
			cs_s1  <= d_in.cs;
			sn_s1  <= d_in.sn;
			e_s2   <= prod2[66:35];
			p_s2   <= p_s1;
			phi_s2 <= phi_s1;
			cs_s2  <= cs_s1;
			sn_s2  <= sn_s1;
			t_s3   <= q;
			phi_s3 <= phi_s2;
			cs_s3  <= cs_n;
			sn_s3  <= sn_n;
		end
	end

	assign d_out = '{t: t_s3, phi: phi_s3, cs: cs_s3, sn: sn_s3};

endmodule

`default_nettype wire

### src/fbl_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fbl_isqrt #(
	parameter int W = 56
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   radicand,
	output logic [W/2-1:0] root
);

	localparam int N = W / 2;

	logic [W-1:0] rem_s [N];
	logic [W-1:0] res_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [W:0] BIT = {{W{1'b0}}, 1'b1} << (2 * (N - 1 - k));
		logic [W-1:0] pr, ps;
		logic [W:0]   cmp;
		logic         ge;

		if (k == 0) begin : g_first
			assign pr = radicand;
			assign ps = '0;
		end else begin : g_next
			assign pr = rem_s[k-1];
			assign ps = res_s[k-1];
		end

		// Try the current bit against the running remainder.
		assign cmp = {1'b0, ps} + BIT;
		assign ge  = {1'b0, pr} >= cmp;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? W'({1'b0, pr} - cmp) : pr;
				res_s[k] <= ge ? (ps >> 1) + BIT[W-1:0] : (ps >> 1);
			end
		end
	end

	assign root = res_s[N-1][N-1:0];

endmodule

`default_nettype wire

### src/fbl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fbl_div #(
	parameter int NW = 56,
	parameter int DW = 28
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] nq_s  [NW];
	logic [DW-1:0] den_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [DW-1:0] pr, pd;
		logic [NW-1:0] pn;
		logic [DW:0]   r2;
		logic          ge;

		if (k == 0) begin : g_first
			assign pr = '0;
			assign pn = num;
			assign pd = den;
		end else begin : g_next
			assign pr = rem_s[k-1];
			assign pn = nq_s[k-1];
			assign pd = den_s[k-1];
		end

		// Shift in the next numerator bit and subtract when it fits.
		assign r2 = {pr, pn[NW-1]};
		assign ge = r2 >= {1'b0, pd};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(r2 - {1'b0, pd}) : r2[DW-1:0];
				nq_s[k]  <= {pn[NW-2:0], ge};
				den_s[k] <= pd;
			end
		end
	end

	assign quo = nq_s[NW-1];

endmodule

`default_nettype wire

### src/fbl_checker.sv
// Port-level checks for the four-bar linkage solver, bound to its top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
`default_nettype none

module fbl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [3:0]         paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready,
	input logic               item_valid,
	input logic               item_ready,
	input logic [15:0]        crank_angle,
	input logic               result_valid,
	input logic               result_ready,
	input logic signed [19:0] tip_x,
	input logic signed [19:0] tip_y,
	input logic signed [19:0] joint_x,
	input logic signed [19:0] joint_y,
	input logic signed [19:0] mid_x,
	input logic signed [19:0] mid_y,
	input logic               valid_res
);

	// A waiting result stays offered.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before its transfer");

	// A waiting result keeps its payload.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(tip_x) && $stable(tip_y) &&
		$stable(joint_x) && $stable(joint_y) && $stable(mid_x) && $stable(mid_y) &&
		$stable(valid_res))
		else $error("result payload changed while stalled");

	// The input side stalls exactly when a result waits untaken.
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready == (!result_valid || result_ready))
		else $error("input ready does not follow the output stall");

	// An open linkage reports zero joint and midpoint.
	a_open_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !valid_res |-> joint_x == 20'sd0 && joint_y == 20'sd0 &&
		mid_x == 20'sd0 && mid_y == 20'sd0)
		else $error("open linkage result carries a nonzero joint");

endmodule

bind four_bar_linkage_solver fbl_checker u_fbl_checker (.*);

`default_nettype wire
